[src/att_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_pkg
// Shared widths, vector types and face pair table for the acute
// tetrahedron test pipeline.
// ----------------------------------------------------------------------------

package att_pkg;

    localparam int COORD_BITS = 8;

    // edge components span -(2^c - 1) .. (2^c - 1)
    localparam int EDGE_W = COORD_BITS + 1;
    // normal components stay below 2 * (2^c - 1)^2 in magnitude
    localparam int NORM_W = 2 * EDGE_W;
    // product of two normal components
    localparam int PROD_W = 2 * NORM_W;
    // sum of three products
    localparam int DOT_W  = PROD_W + 2;

    localparam int NUM_EDGES = 5;
    localparam int NUM_NORMS = 4;
    localparam int NUM_PAIRS = 6;

    typedef struct packed {
        logic signed [EDGE_W-1:0] x;
        logic signed [EDGE_W-1:0] y;
        logic signed [EDGE_W-1:0] z;
    } edge_vec_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } norm_vec_t;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef int pair_tab_t [NUM_PAIRS];

    // face pairs whose normals are dotted
    localparam pair_tab_t PAIR_FIRST  = '{0, 0, 0, 1, 1, 2};
    localparam pair_tab_t PAIR_SECOND = '{1, 2, 3, 2, 3, 3};

endpackage

[src/acute_tetrahedron_test_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acute_tetrahedron_test_core
// Tests whether a lattice tetrahedron has all six dihedral angles acute.
//
// A request carries the four vertices a, b, c, d as unsigned coordinates
// and is taken when in_valid is high and in_stall is low. Each request
// gives exactly one result, is_acute, handed over when out_valid is high
// and out_stall is low. Coplanar or coincident vertices give is_acute 0.
// The pipeline has five register stages: edge vectors, face normals,
// normal component products, dot product signs, and the output register.
// A request moves through the five registers in that order before its
// result shows on out_valid; one request is taken every cycle while
// in_stall is low.
// When the receiver stalls, stages holding data freeze while empty stages
// ahead of them still fill, so bubbles close up; in_stall rises once every
// stage is occupied. Reset clears all stage valid bits; results in flight
// are dropped.
// ----------------------------------------------------------------------------

module acute_tetrahedron_test_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [att_pkg::COORD_BITS-1:0] a_x,
    input  logic [att_pkg::COORD_BITS-1:0] a_y,
    input  logic [att_pkg::COORD_BITS-1:0] a_z,
    input  logic [att_pkg::COORD_BITS-1:0] b_x,
    input  logic [att_pkg::COORD_BITS-1:0] b_y,
    input  logic [att_pkg::COORD_BITS-1:0] b_z,
    input  logic [att_pkg::COORD_BITS-1:0] c_x,
    input  logic [att_pkg::COORD_BITS-1:0] c_y,
    input  logic [att_pkg::COORD_BITS-1:0] c_z,
    input  logic [att_pkg::COORD_BITS-1:0] d_x,
    input  logic [att_pkg::COORD_BITS-1:0] d_y,
    input  logic [att_pkg::COORD_BITS-1:0] d_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           is_acute
);

    // stage valid bits and enables
    logic edge_valid_reg;
    logic norm_valid_reg;
    logic prod_valid_reg;
    logic sign_valid_reg;
    logic out_valid_reg;

    logic out_en;
    logic sign_en;
    logic prod_en;
    logic norm_en;
    logic edge_en;

    // payload
    att_pkg::edge_vec_t edge_reg [att_pkg::NUM_EDGES];
    att_pkg::edge_vec_t edge_next [att_pkg::NUM_EDGES];
    att_pkg::norm_vec_t norm_reg [att_pkg::NUM_NORMS];
    att_pkg::norm_vec_t norm_next [att_pkg::NUM_NORMS];
    att_pkg::prod_t     prod_reg [att_pkg::NUM_PAIRS][3];
    logic signed [att_pkg::DOT_W-1:0] dot_next [att_pkg::NUM_PAIRS];
    logic [att_pkg::NUM_PAIRS-1:0]    neg_next;
    logic [att_pkg::NUM_PAIRS-1:0]    neg_reg;
    logic                             is_acute_reg;

    assign out_en  = !out_valid_reg  || !out_stall;
    assign sign_en = !sign_valid_reg || out_en;
    assign prod_en = !prod_valid_reg || sign_en;
    assign norm_en = !norm_valid_reg || prod_en;
    assign edge_en = !edge_valid_reg || norm_en;

    assign in_stall  = !edge_en;
    assign out_valid = out_valid_reg;
    assign is_acute  = is_acute_reg;

    // edge vectors b-a, c-a, d-a, c-b, d-b
    always_comb
    begin
        edge_next[0].x = $signed({1'b0, b_x}) - $signed({1'b0, a_x});
        edge_next[0].y = $signed({1'b0, b_y}) - $signed({1'b0, a_y});
        edge_next[0].z = $signed({1'b0, b_z}) - $signed({1'b0, a_z});
        edge_next[1].x = $signed({1'b0, c_x}) - $signed({1'b0, a_x});
        edge_next[1].y = $signed({1'b0, c_y}) - $signed({1'b0, a_y});
        edge_next[1].z = $signed({1'b0, c_z}) - $signed({1'b0, a_z});
        edge_next[2].x = $signed({1'b0, d_x}) - $signed({1'b0, a_x});
        edge_next[2].y = $signed({1'b0, d_y}) - $signed({1'b0, a_y});
        edge_next[2].z = $signed({1'b0, d_z}) - $signed({1'b0, a_z});
        edge_next[3].x = $signed({1'b0, c_x}) - $signed({1'b0, b_x});
        edge_next[3].y = $signed({1'b0, c_y}) - $signed({1'b0, b_y});
        edge_next[3].z = $signed({1'b0, c_z}) - $signed({1'b0, b_z});
        edge_next[4].x = $signed({1'b0, d_x}) - $signed({1'b0, b_x});
        edge_next[4].y = $signed({1'b0, d_y}) - $signed({1'b0, b_y});
        edge_next[4].z = $signed({1'b0, d_z}) - $signed({1'b0, b_z});
    end

    // face normals
    att_cross u_cross_0 (.u(edge_reg[4]), .v(edge_reg[3]), .n(norm_next[0]));
    att_cross u_cross_1 (.u(edge_reg[1]), .v(edge_reg[2]), .n(norm_next[1]));
    att_cross u_cross_2 (.u(edge_reg[2]), .v(edge_reg[0]), .n(norm_next[2]));
    att_cross u_cross_3 (.u(edge_reg[0]), .v(edge_reg[1]), .n(norm_next[3]));

    // dot product sums and signs
    always_comb
    begin
        for (int p = 0; p < att_pkg::NUM_PAIRS; p++)
        begin
            dot_next[p] = att_pkg::DOT_W'(prod_reg[p][0])
                        + att_pkg::DOT_W'(prod_reg[p][1])
                        + att_pkg::DOT_W'(prod_reg[p][2]);
            neg_next[p] = dot_next[p][att_pkg::DOT_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_valid_reg <= 1'b0;
            norm_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            sign_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (edge_en)
                edge_valid_reg <= in_valid;
            if (norm_en)
                norm_valid_reg <= edge_valid_reg;
            if (prod_en)
                prod_valid_reg <= norm_valid_reg;
            if (sign_en)
                sign_valid_reg <= prod_valid_reg;
            if (out_en)
                out_valid_reg <= sign_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (edge_en)
            edge_reg <= edge_next;
        if (norm_en)
            norm_reg <= norm_next;
        if (prod_en)
        begin
            for (int p = 0; p < att_pkg::NUM_PAIRS; p++)
            begin
                prod_reg[p][0] <= norm_reg[att_pkg::PAIR_FIRST[p]].x
                                * norm_reg[att_pkg::PAIR_SECOND[p]].x;
                prod_reg[p][1] <= norm_reg[att_pkg::PAIR_FIRST[p]].y
                                * norm_reg[att_pkg::PAIR_SECOND[p]].y;
                prod_reg[p][2] <= norm_reg[att_pkg::PAIR_FIRST[p]].z
                                * norm_reg[att_pkg::PAIR_SECOND[p]].z;
            end
        end
        if (sign_en)
            neg_reg <= neg_next;
        if (out_en)
            is_acute_reg <= &neg_reg;
    end

endmodule

[src/att_cross.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_cross
// Exact signed cross product of two lattice edge vectors, giving one
// face normal.
// ----------------------------------------------------------------------------

module att_cross (
    input  att_pkg::edge_vec_t u,
    input  att_pkg::edge_vec_t v,
    output att_pkg::norm_vec_t n
);

    logic signed [att_pkg::NORM_W-1:0] yz;
    logic signed [att_pkg::NORM_W-1:0] zy;
    logic signed [att_pkg::NORM_W-1:0] zx;
    logic signed [att_pkg::NORM_W-1:0] xz;
    logic signed [att_pkg::NORM_W-1:0] xy;
    logic signed [att_pkg::NORM_W-1:0] yx;

    assign yz = u.y * v.z;
    assign zy = u.z * v.y;
    assign zx = u.z * v.x;
    assign xz = u.x * v.z;
    assign xy = u.x * v.y;
    assign yx = u.y * v.x;

    assign n.x = yz - zy;
    assign n.y = zx - xz;
    assign n.z = xy - yx;

endmodule

[tb/acute_tetrahedron_test_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acute_tetrahedron_test_core_tb
// Self-checking bench for the acute tetrahedron test core.
//
// A driver sends vertex sets from a queue filled at start: a directed
// group first (extreme coordinates, regular and right-corner shapes,
// coplanar, collinear and coincident vertices), then random sets. Most
// random sets are regular shapes, some jittered, so the acute case is hit
// often. The rest are right-corner shapes, full-range noise, tiny shapes
// and degenerate sets. Each accepted request is scored by an exact integer
// model of the face normal dot products. A monitor compares every result
// with the oldest pending prediction. Both sides idle in random bursts;
// the receiver holds off once for a long stretch to back up the pipeline.
// ----------------------------------------------------------------------------

module acute_tetrahedron_test_core_tb;

    localparam int CW           = att_pkg::COORD_BITS;
    localparam int CMAX         = (1 << CW) - 1;
    localparam int NUM_RANDOM   = 900;
    localparam int CALM_TAIL    = 100;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // coordinate order: a_x a_y a_z b_x b_y b_z c_x c_y c_z d_x d_y d_z
    typedef logic [11:0][CW-1:0] tet_t;

    typedef struct packed {
        tet_t tet;
        logic acute;
    } verdict_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b1;
    tet_t drv_tet   = '0;
    logic in_stall;
    logic out_valid;
    logic is_acute;

    tet_t     tet_pending [$];
    verdict_t acute_due [$];

    int total        = 0;
    int launched     = 0;
    int accepted     = 0;
    int delivered    = 0;
    int fail_cnt     = 0;
    int src_gap      = 0;
    int sink_gap     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    bit held         = 1'b0;
    verdict_t due;

    acute_tetrahedron_test_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a_x       (drv_tet[0]),
        .a_y       (drv_tet[1]),
        .a_z       (drv_tet[2]),
        .b_x       (drv_tet[3]),
        .b_y       (drv_tet[4]),
        .b_z       (drv_tet[5]),
        .c_x       (drv_tet[6]),
        .c_y       (drv_tet[7]),
        .c_z       (drv_tet[8]),
        .d_x       (drv_tet[9]),
        .d_y       (drv_tet[10]),
        .d_z       (drv_tet[11]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_acute  (is_acute)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scoring
    // ------------------------------------------------------------------

    // difference of two vertices wraps correctly into the signed edge width
    function automatic att_pkg::edge_vec_t edge_between(tet_t t, int p, int q);
        att_pkg::edge_vec_t r;
        r.x = t[q*3]   - t[p*3];
        r.y = t[q*3+1] - t[p*3+1];
        r.z = t[q*3+2] - t[p*3+2];
        return r;
    endfunction

    function automatic att_pkg::norm_vec_t cross_of(att_pkg::edge_vec_t u,
                                                    att_pkg::edge_vec_t v);
        att_pkg::norm_vec_t n;
        n.x = $signed(u.y) * $signed(v.z) - $signed(u.z) * $signed(v.y);
        n.y = $signed(u.z) * $signed(v.x) - $signed(u.x) * $signed(v.z);
        n.z = $signed(u.x) * $signed(v.y) - $signed(u.y) * $signed(v.x);
        return n;
    endfunction

    function automatic logic dot_below_zero(att_pkg::norm_vec_t p, att_pkg::norm_vec_t q);
        logic signed [att_pkg::DOT_W-1:0] s;
        s = $signed(p.x) * $signed(q.x) + $signed(p.y) * $signed(q.y)
          + $signed(p.z) * $signed(q.z);
        return s[att_pkg::DOT_W-1];
    endfunction

    function automatic logic acute_predict(tet_t t);
        att_pkg::edge_vec_t ab;
        att_pkg::edge_vec_t ac;
        att_pkg::edge_vec_t ad;
        att_pkg::edge_vec_t bc;
        att_pkg::edge_vec_t bd;
        att_pkg::norm_vec_t n [4];
        logic all_neg;
        ab = edge_between(t, 0, 1);
        ac = edge_between(t, 0, 2);
        ad = edge_between(t, 0, 3);
        bc = edge_between(t, 1, 2);
        bd = edge_between(t, 1, 3);
        n[0] = cross_of(bd, bc);
        n[1] = cross_of(ac, ad);
        n[2] = cross_of(ad, ab);
        n[3] = cross_of(ab, ac);
        all_neg = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = i + 1; k < 4; k++)
            begin
                if (!dot_below_zero(n[i], n[k]))
                    all_neg = 1'b0;
            end
        end
        return all_neg;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    function automatic tet_t tet_of(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz, int dx, int dy, int dz);
        tet_t t;
        t[0] = CW'(ax);  t[1]  = CW'(ay);  t[2]  = CW'(az);
        t[3] = CW'(bx);  t[4]  = CW'(by);  t[5]  = CW'(bz);
        t[6] = CW'(cx);  t[7]  = CW'(cy);  t[8]  = CW'(cz);
        t[9] = CW'(dx);  t[10] = CW'(dy);  t[11] = CW'(dz);
        return t;
    endfunction

    function automatic logic [CW-1:0] clip(int v);
        if (v < 0)
            return '0;
        if (v > CMAX)
            return '1;
        return v[CW-1:0];
    endfunction

    task automatic queue_random(int count);
        tet_t t;
        logic [3*CW-1:0] vtx;
        int c [12];
        int o [3];
        int kind;
        int s;
        int j;
        int ax;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            s = $urandom_range(2, CMAX);
            j = (kind < 30) ? 0 : $urandom_range(0, s / 3);
            for (int i = 0; i < 3; i++)
                o[i] = $urandom_range(0, CMAX - s);
            for (int k = 0; k < 4; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (kind < 55)
                        // regular shape inscribed in a cube, jittered when j is not 0
                        c[k*3+i] = o[i] + ((k != 0 && k != 3 - i) ? s : 0)
                                 + int'($urandom_range(0, 2 * j)) - j;
                    else if (kind < 65)
                        // right corner with legs along the axes
                        c[k*3+i] = o[i] + ((k == i + 1) ? s : 0)
                                 + int'($urandom_range(0, 2 * j)) - j;
                    else if (kind < 80)
                        c[k*3+i] = $urandom_range(0, CMAX);
                    else if (kind < 90)
                        c[k*3+i] = o[i] + $urandom_range(0, 3);
                    else
                        c[k*3+i] = $urandom_range(0, CMAX);
                end
            end
            if (kind >= 90)
            begin
                // coplanar along one axis, or a repeated vertex
                ax = $urandom_range(0, 2);
                if ($urandom_range(0, 1) == 0)
                begin
                    for (int k = 1; k < 4; k++)
                        c[k*3+ax] = c[ax];
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        c[9+i] = c[ax*3+i];
                end
            end
            for (int i = 0; i < 12; i++)
                t[i] = clip(c[i]);
            // shuffle vertex order
            for (int k = 3; k > 0; k--)
            begin
                pick = $urandom_range(0, k);
                vtx = {t[k*3+2], t[k*3+1], t[k*3]};
                for (int i = 0; i < 3; i++)
                begin
                    t[k*3+i] = t[pick*3+i];
                    t[pick*3+i] = vtx[i*CW +: CW];
                end
            end
            tet_pending.push_back(t);
        end
    endtask

    function automatic bit idling_on();
        return tet_pending.size() > CALM_TAIL && (launched / 150) % 4 != 3;
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                acute_due.push_back({drv_tet, acute_predict(drv_tet)});
                accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (tet_pending.size() > 0)
                begin
                    drv_tet <= tet_pending.pop_front();
                    in_valid <= 1'b1;
                    launched++;
                    if (idling_on() && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 13);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                delivered++;
                if (acute_due.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("ERROR: result with no request pending, is_acute=%b",
                                 is_acute);
                end
                else
                begin
                    due = acute_due.pop_front();
                    if (is_acute !== due.acute)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display({"ERROR: a=(%0d,%0d,%0d) b=(%0d,%0d,%0d) ",
                                      "c=(%0d,%0d,%0d) d=(%0d,%0d,%0d) ",
                                      "is_acute expected %b got %b"},
                                     due.tet[0], due.tet[1], due.tet[2],
                                     due.tet[3], due.tet[4], due.tet[5],
                                     due.tet[6], due.tet[7], due.tet[8],
                                     due.tet[9], due.tet[10], due.tet[11],
                                     due.acute, is_acute);
                    end
                end
            end
            if (!held && delivered >= HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                out_stall <= 1'b1;
            end
            else if (idling_on() && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        // all zero, all max, coincident
        tet_pending.push_back(tet_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        tet_pending.push_back(tet_of(255, 255, 255, 255, 255, 255,
                                     255, 255, 255, 255, 255, 255));
        tet_pending.push_back(tet_of(0, 0, 0, 255, 255, 255,
                                     255, 255, 255, 255, 255, 255));
        // regular shapes, both orientations
        tet_pending.push_back(tet_of(0, 0, 0, 255, 255, 0, 255, 0, 255, 0, 255, 255));
        tet_pending.push_back(tet_of(0, 0, 0, 255, 0, 255, 255, 255, 0, 0, 255, 255));
        tet_pending.push_back(tet_of(0, 0, 0, 1, 1, 0, 1, 0, 1, 0, 1, 1));
        tet_pending.push_back(tet_of(255, 255, 255, 0, 0, 255, 0, 255, 0, 255, 0, 0));
        tet_pending.push_back(tet_of(85, 85, 85, 170, 170, 85, 170, 85, 170, 85, 170, 170));
        tet_pending.push_back(tet_of(0, 0, 0, 10, 10, 0, 10, 0, 10, 0, 10, 11));
        // right corners give zero dot products
        tet_pending.push_back(tet_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        tet_pending.push_back(tet_of(0, 0, 0, 255, 0, 0, 0, 255, 0, 0, 0, 255));
        tet_pending.push_back(tet_of(255, 255, 255, 0, 255, 255, 255, 0, 255, 255, 255, 0));
        // coplanar, collinear, repeated vertex
        tet_pending.push_back(tet_of(0, 0, 7, 255, 0, 7, 0, 255, 7, 100, 100, 7));
        tet_pending.push_back(tet_of(0, 0, 0, 1, 1, 1, 2, 2, 2, 200, 10, 3));
        tet_pending.push_back(tet_of(9, 40, 200, 9, 40, 200, 130, 7, 66, 255, 255, 0));
        // flat and needle shapes
        tet_pending.push_back(tet_of(0, 0, 0, 255, 0, 0, 0, 255, 0, 128, 128, 1));
        tet_pending.push_back(tet_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 255, 255, 255));
        tet_pending.push_back(tet_of(170, 85, 170, 85, 170, 85, 255, 0, 255, 0, 255, 0));
        queue_random(NUM_RANDOM);
        total = tet_pending.size();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted < total || acute_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[acute_tetrahedron_test_core.f]
src/att_pkg.sv
src/att_cross.sv
src/acute_tetrahedron_test_core.sv
tb/acute_tetrahedron_test_core_tb.sv
